@@ rtl/qips_pkg.sv @@
// ----------------------------------------------------------------------------
// qips_pkg: shared constants and types of the quantized inner product scorer
// Field widths, register indexes, the companded level table built at
// elaboration, and the job record handed to the result unit.
// ----------------------------------------------------------------------------
package qips_pkg;

	// fixed point and field widths
	localparam int FRACTION_BITS = 16;
	localparam int MAX_DIMENSION = 1024;
	localparam int MAG_W         = 23;
	localparam int SUM_W         = 34;
	localparam int HALF_SUM_W    = SUM_W / 2;
	localparam int SCALE_W       = 24;
	localparam int LVL_W         = FRACTION_BITS + 1;
	localparam int CODE_W        = 7;
	localparam int NUM_CURVES    = 7;
	localparam int NUM_CODES     = 1 << CODE_W;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS     = 2'd1;
	localparam logic [10:0] VLEN_RESET  = 11'd1024;
	localparam logic [3:0]  CBITS_RESET = 4'd4;

	typedef logic [NUM_CURVES-1:0][NUM_CODES-1:0][LVL_W-1:0] lvl_rom_t;

	// finished sums of one vector, handed to the result unit
	typedef struct packed {
		logic               start;
		logic [SUM_W-1:0]   base;
		logic [SUM_W-1:0]   agree;
		logic [SCALE_W-1:0] scale;
	} fin_job_t;

	// ln(1+mu) in Q30 for each companding curve
	function automatic logic [63:0] ln_q30(input int unsigned s);
		logic [63:0] v;
		case (s)
			0: v = 64'd239598564;
			1: v = 64'd435364845;
			2: v = 64'd435364845;
			3: v = 64'd744261118;
			4: v = 64'd870729690;
			5: v = 64'd983859682;
			default: v = 64'd1179625963;
		endcase
		return v;
	endfunction

	// mu in quarters for each companding curve
	function automatic int unsigned mu_quarters(input int unsigned s);
		int unsigned v;
		case (s)
			0: v = 1;
			1: v = 2;
			2: v = 2;
			3: v = 4;
			4: v = 5;
			5: v = 6;
			default: v = 8;
		endcase
		return v;
	endfunction

	// divide by one of the small divisors the table build needs
	function automatic logic [63:0] div_small(input logic [63:0] n, input int unsigned d);
		logic [63:0] q;
		case (d)
			1: q = n;          2: q = n / 2;      3: q = n / 3;      4: q = n / 4;
			5: q = n / 5;      6: q = n / 6;      7: q = n / 7;      8: q = n / 8;
			9: q = n / 9;      10: q = n / 10;    11: q = n / 11;    12: q = n / 12;
			13: q = n / 13;    14: q = n / 14;    15: q = n / 15;    16: q = n / 16;
			17: q = n / 17;    18: q = n / 18;    19: q = n / 19;    20: q = n / 20;
			21: q = n / 21;    22: q = n / 22;    23: q = n / 23;    24: q = n / 24;
			25: q = n / 25;    26: q = n / 26;    27: q = n / 27;    28: q = n / 28;
			29: q = n / 29;    30: q = n / 30;    31: q = n / 31;    32: q = n / 32;
			33: q = n / 33;    34: q = n / 34;    35: q = n / 35;    36: q = n / 36;
			37: q = n / 37;    38: q = n / 38;    39: q = n / 39;    40: q = n / 40;
			41: q = n / 41;    63: q = n / 63;    127: q = n / 127;
			default: q = n;
		endcase
		return q;
	endfunction

	// build the companded level table: ((1+mu)^(c/M) - 1) / mu in Q.F
	function automatic lvl_rom_t build_level_rom();
		lvl_rom_t    rom;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] lev;
		logic [63:0] one;
		int unsigned m;
		int unsigned k;
		rom = '0;
		one = 64'd1 << FRACTION_BITS;
		for (int unsigned s = 0; s < NUM_CURVES; s++) begin
			m = (1 << (s + 1)) - 1;
			for (int unsigned c = 0; c < NUM_CODES; c++) begin
				if (c <= m) begin
					x = div_small(64'(c) * ln_q30(s) + 64'(m >> 1), m);
					term = x;
					sum = '0;
					k = 1;
					// Taylor series of exp(x)-1, stop at the first zero term
					for (int i = 0; i < 40; i++) begin
						if (term != 64'd0 && k <= 40) begin
							sum = sum + term;
							k = k + 1;
							term = div_small((term * x) >> 30, k);
						end
					end
					lev = div_small(sum * 64'd4, mu_quarters(s));
					lev = (lev + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS);
					if (lev > one) begin
						lev = one;
					end
					rom[s][c] = lev[LVL_W-1:0];
				end
			end
		end
		return rom;
	endfunction

	localparam lvl_rom_t LEVEL_ROM = build_level_rom();

endpackage

@@ rtl/quantized_inner_product_scorer.sv @@
// ----------------------------------------------------------------------------
// quantized_inner_product_scorer: lookup-table inner product scoring
// Load items write a query coordinate into the query memory; score items
// stream the elements of one stored vector and accumulate weighted sums.
// ----------------------------------------------------------------------------
// Timing: a load item takes effect from the cycle after it is accepted; a result
//   item is presented once the result unit has finished the sums of the vector.
// Throughput: one item per cycle while a vector streams; after a last element
//   the input stalls through three pipeline stages, four steps of the shared
//   24x17 multiplier, rounding and output load, longer while a result is held.
// Reset: position, sums and valids clear; the query memory is not cleared.
module quantized_inner_product_scorer #(
	parameter int MAX_DIMENSION = qips_pkg::MAX_DIMENSION
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                kind,
	input  logic [9:0]          coord_index,
	input  logic signed [23:0]  query_value,
	input  logic [6:0]          level_code,
	input  logic                elem_sign,
	input  logic [23:0]         vector_scale,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [41:0]  mse_part,
	output logic        [42:0]  qjl_part,
	output logic signed [43:0]  combined
);

	localparam int AW  = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
	localparam int CW  = (AW + 1 > 11) ? AW + 1 : 11;
	localparam int MW  = qips_pkg::MAG_W;
	localparam int LW  = qips_pkg::LVL_W;
	localparam int SW  = qips_pkg::SUM_W;
	localparam int PW  = MW + LW;
	localparam int FB  = qips_pkg::FRACTION_BITS;
	localparam int WW  = PW + 1 - FB;

	// configuration registers
	logic [10:0]  vlen_q;
	logic [3:0]   cbits_q;

	// query memory: nonnegative flag over magnitude
	logic [MW:0]  qmem [MAX_DIMENSION];

	logic [AW-1:0] pos_q;
	logic [SW-1:0] base_q;
	logic [SW-1:0] agree_q;

	logic                       vld_s1, last_s1, sign_s1;
	logic [MW:0]                rd_s1;
	logic [LW-1:0]              lvl_s1;
	logic [qips_pkg::SCALE_W-1:0] scale_s1;
	logic                       vld_s2, last_s2, agree_s2;
	logic [PW-1:0]              prod_s2;
	logic [qips_pkg::SCALE_W-1:0] scale_s2;
	logic                       vld_s3, last_s3, agree_s3;
	logic [WW-1:0]              weight_s3;
	logic [qips_pkg::SCALE_W-1:0] scale_s3;

	logic          acc, ld, sc, ld_ok, last_s0, fin_busy;
	logic [CW-1:0] vlen_ext, len_eff, idx_ext;
	logic [AW-1:0] ld_addr;
	logic [23:0]   neg_val;
	logic [MW-1:0] ld_mag;
	logic [3:0]    cb;
	logic [2:0]    sel;
	logic [6:0]    code_m;
	logic [PW:0]   prod_rnd;
	logic [SW-1:0] base_nx, agree_nx;
	qips_pkg::fin_job_t job;

	// take configuration writes; unknown indexes do nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q  <= qips_pkg::VLEN_RESET;
			cbits_q <= qips_pkg::CBITS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				qips_pkg::REG_VECTOR_LENGTH: vlen_q <= cfg_data;
				qips_pkg::REG_CODE_BITS:     cbits_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// stall while a last element or its result is being worked on
	assign in_stall = (vld_s1 && last_s1) || (vld_s2 && last_s2) || (vld_s3 && last_s3)
		|| fin_busy;

	assign acc = in_valid && !in_stall;
	assign ld  = acc && !kind;
	assign sc  = acc && kind;

	// clamp the vector length and detect the last element
	assign vlen_ext = CW'(vlen_q);
	assign len_eff  = (vlen_q == 11'd0) ? CW'(1) :
		((vlen_ext > CW'(MAX_DIMENSION)) ? CW'(MAX_DIMENSION) : vlen_ext);
	assign last_s0  = (CW'(pos_q) + CW'(1)) >= len_eff;

	// load: range check, magnitude with saturation, sign
	assign idx_ext = CW'(coord_index);
	assign ld_ok   = idx_ext < CW'(MAX_DIMENSION);
	assign ld_addr = idx_ext[AW-1:0];
	assign neg_val = ~query_value + 24'd1;
	assign ld_mag  = !query_value[23] ? query_value[MW-1:0] :
		(neg_val[23] ? qips_pkg::MAG_MAX : neg_val[MW-1:0]);

	// clamp code bits, pick the curve and mask the level code
	assign cb     = (cbits_q < 4'd2) ? 4'd2 : ((cbits_q > 4'd8) ? 4'd8 : cbits_q);
	assign sel    = 3'(cb - 4'd2);
	assign code_m = level_code & (7'h7f >> (4'd8 - cb));

	// query memory: write on load, read the current position on score
	always_ff @(posedge clk) begin
		if (ld && ld_ok) begin
			qmem[ld_addr] <= {!query_value[23], ld_mag};
		end
		if (sc) begin
			rd_s1 <= qmem[pos_q];
		end
	end

	// advance the element position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (sc) begin
			pos_q <= last_s0 ? '0 : pos_q + 1'b1;
		end
	end

	// pipeline valids and last flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
			vld_s3  <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			vld_s1  <= sc;
			last_s1 <= sc && last_s0;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
			vld_s3  <= vld_s2;
			last_s3 <= last_s2;
		end
	end

	assign prod_rnd = {1'b0, prod_s2} + (PW + 1)'(1 << (FB - 1));

	// pipeline payload: level lookup, product, rounded weight
	always_ff @(posedge clk) begin
		if (sc) begin
			lvl_s1   <= qips_pkg::LEVEL_ROM[sel][code_m];
			sign_s1  <= elem_sign;
			scale_s1 <= vector_scale;
		end
		prod_s2   <= PW'(rd_s1[MW-1:0]) * PW'(lvl_s1);
		agree_s2  <= (sign_s1 == rd_s1[MW]);
		scale_s2  <= scale_s1;
		weight_s3 <= prod_rnd[PW:FB];
		agree_s3  <= agree_s2;
		scale_s3  <= scale_s2;
	end

	// accumulate the weight; agreeing signs add it twice
	assign base_nx  = base_q + SW'(weight_s3);
	assign agree_nx = agree_q + (agree_s3 ? SW'({weight_s3, 1'b0}) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			agree_q <= '0;
		end else if (vld_s3) begin
			base_q  <= last_s3 ? '0 : base_nx;
			agree_q <= last_s3 ? '0 : agree_nx;
		end
	end

	// hand the finished sums to the result unit
	assign job.start = vld_s3 && last_s3;
	assign job.base  = base_nx;
	assign job.agree = agree_nx;
	assign job.scale = scale_s3;

	qips_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.busy      (fin_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.mse_part  (mse_part),
		.qjl_part  (qjl_part),
		.combined  (combined)
	);

	// a last element wraps the position to the start
	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(sc && last_s0) |=> pos_q == '0)
		else $error("position not cleared after last element");

	// sums start from zero after a vector is handed off
	a_sum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		job.start |=> (base_q == '0 && agree_q == '0))
		else $error("sums not cleared after result handoff");

	// the result unit only starts on a last element
	a_fin_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_busy) |-> $past(vld_s3 && last_s3))
		else $error("result unit started without a last element");

endmodule

@@ rtl/qips_finish.sv @@
// ----------------------------------------------------------------------------
// qips_finish: result unit of the scorer
// Scales the two finished sums of a vector with one shared 24x17 multiplier
// over four steps, rounds both parts and holds the result in the output
// register until the item is taken.
// ----------------------------------------------------------------------------
module qips_finish (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qips_pkg::fin_job_t   job,
	output logic                 busy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [41:0]   mse_part,
	output logic        [42:0]   qjl_part,
	output logic signed [43:0]   combined
);

	localparam int PROD_W = qips_pkg::SCALE_W + qips_pkg::HALF_SUM_W;
	localparam int ACC_W  = qips_pkg::SCALE_W + qips_pkg::SUM_W;
	localparam int HS     = qips_pkg::HALF_SUM_W;
	localparam int FB     = qips_pkg::FRACTION_BITS;
	localparam int MAGO_W = ACC_W + 1 - FB;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_RND  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                     state_q;
	logic [2:0]                     step_q;
	logic [qips_pkg::SUM_W-1:0]     base_q;
	logic [qips_pkg::SUM_W-1:0]     agree_q;
	logic [qips_pkg::SCALE_W-1:0]   scale_q;
	logic [PROD_W-1:0]              prod_q;
	logic [ACC_W-1:0]               acc_base_q;
	logic [ACC_W-1:0]               acc_agree_q;
	logic [MAGO_W-1:0]              mse_mag_q;
	logic [MAGO_W-1:0]              qjl_mag_q;
	logic                           out_valid_q;
	logic [41:0]                    mse_q;
	logic [42:0]                    qjl_q;
	logic [43:0]                    cmb_q;

	logic [HS-1:0]                  opnd;
	logic [1:0]                     prev;
	logic [ACC_W-1:0]               addend;
	logic [ACC_W:0]                 rnd_base;
	logic [ACC_W:0]                 rnd_agree;
	logic                           out_free;

	// pick the sum half for this multiply step
	always_comb begin
		case (step_q[1:0])
			2'd0: opnd = base_q[HS-1:0];
			2'd1: opnd = base_q[qips_pkg::SUM_W-1:HS];
			2'd2: opnd = agree_q[HS-1:0];
			2'd3: opnd = agree_q[qips_pkg::SUM_W-1:HS];
			default: opnd = '0;
		endcase
	end

	// align the previous product by its half
	assign prev   = 2'(step_q - 3'd1);
	assign addend = prev[0] ? {prod_q, {HS{1'b0}}} : ACC_W'(prod_q);

	assign rnd_base  = {1'b0, acc_base_q} + (ACC_W + 1)'(1 << (FB - 1));
	assign rnd_agree = {1'b0, acc_agree_q} + (ACC_W + 1)'(1 << (FB - 1));

	assign out_free = !out_valid_q || !out_stall;

	// sequence multiply, accumulate, round and output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise valid on the output step, drop it once the item is taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job.start) begin
						step_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: operands, product, accumulators and output payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && job.start) begin
			base_q      <= job.base;
			agree_q     <= job.agree;
			scale_q     <= job.scale;
			acc_base_q  <= '0;
			acc_agree_q <= '0;
		end
		if (state_q == ST_MUL) begin
			if (step_q < 3'd4) begin
				prod_q <= PROD_W'(scale_q) * PROD_W'(opnd);
			end
			if (step_q != 3'd0) begin
				if (prev[1]) begin
					acc_agree_q <= acc_agree_q + addend;
				end else begin
					acc_base_q <= acc_base_q + addend;
				end
			end
		end
		if (state_q == ST_RND) begin
			mse_mag_q <= rnd_base[ACC_W:FB];
			qjl_mag_q <= rnd_agree[ACC_W:FB];
		end
		if (state_q == ST_OUT && out_free) begin
			mse_q <= 42'(~mse_mag_q + 1'b1);
			qjl_q <= 43'(qjl_mag_q);
			cmb_q <= 44'(qjl_mag_q) - 44'(mse_mag_q);
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign mse_part  = mse_q;
	assign qjl_part  = qjl_q;
	assign combined  = cmb_q;

	// a job arrives only while the unit is free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job.start |-> state_q == ST_IDLE)
		else $error("result job arrived while result unit busy");

	// a free output register takes the result on the output step
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !out_valid_q) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("result not loaded into free output register");

	// hold the output item while the receiver stalls
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=>
		(out_valid_q && $stable(mse_q) && $stable(qjl_q) && $stable(cmb_q)))
		else $error("stalled result item changed");

endmodule

@@ tb/tb_quantized_inner_product_scorer.sv @@
// ----------------------------------------------------------------------------
// tb_quantized_inner_product_scorer: self-checking bench for the scorer
// Loads query coordinates and streams vector elements through the valid/stall
// input, predicts every score from its own copy of the query store, sums and
// companded level table, and checks each output item field by field. A short
// table of corner cases runs first, then random phases with varied vector
// length, code width and idling on both channels.
// ----------------------------------------------------------------------------
module tb_quantized_inner_product_scorer;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_SCORE = 1'b1;
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int NUM_PHASES     = 12;
	localparam int FILL_ENTRIES   = 64;
	localparam int PHASE_ITEMS    = 26;

	// ln(1+mu) in Q30 and mu in quarters, one entry per companding curve
	localparam logic [6:0][31:0] LN1P_Q30 = {32'd1179625963, 32'd983859682, 32'd870729690,
		32'd744261118, 32'd435364845, 32'd435364845, 32'd239598564};
	localparam logic [6:0][3:0] MU_Q = {4'd8, 4'd6, 4'd5, 4'd4, 4'd2, 4'd2, 4'd1};

	typedef enum logic [1:0] {ROW_REG, ROW_LOAD, ROW_SCORE, ROW_SCORE_NULL} row_op_t;
	typedef enum int {MODE_STEADY, MODE_SENDER_IDLE, MODE_RECEIVER_STALL, MODE_BOTH} idle_mode_t;

	typedef struct packed {
		logic        kind;
		logic [9:0]  coord;
		logic [23:0] qval;
		logic [6:0]  code;
		logic        sgn;
		logic [23:0] scale;
	} item_t;

	typedef struct packed {
		logic signed [41:0] mse;
		logic        [42:0] qjl;
		logic signed [43:0] cmb;
	} score_t;

	// directed rows: register writes (index, value) or items; a null score expects zeros
	typedef struct packed {
		row_op_t     op;
		logic [9:0]  index;
		logic [23:0] value;
		logic [6:0]  code;
		logic        sgn;
		logic [23:0] scale;
	} row_t;

	localparam int NUM_ROWS = 31;
	localparam row_t DIRECTED [NUM_ROWS] = '{
		'{ROW_REG,        10'(qips_pkg::REG_VECTOR_LENGTH), 24'd1, 7'h00, 1'b0, 24'h000000},
		// zero query magnitude
		'{ROW_LOAD,       10'd0,    24'h000000, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE_NULL, 10'd0,    24'h000000, 7'h05, 1'b1, 24'hFFFFFF},
		// most negative query saturates; level code zero; top code; zero scale
		'{ROW_LOAD,       10'd0,    24'h800000, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE_NULL, 10'd0,    24'h000000, 7'h00, 1'b0, 24'hFFFFFF},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h07, 1'b0, 24'hFFFFFF},
		'{ROW_SCORE_NULL, 10'd0,    24'h000000, 7'h07, 1'b1, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h7F, 1'b1, 24'h000001},
		// largest positive query
		'{ROW_LOAD,       10'd0,    24'h7FFFFF, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h07, 1'b1, 24'hFFFFFF},
		// code width below and above the legal range, then both ends
		'{ROW_REG,        10'(qips_pkg::REG_CODE_BITS), 24'd0, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h7F, 1'b1, 24'h800000},
		'{ROW_REG,        10'(qips_pkg::REG_CODE_BITS), 24'd15, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h7F, 1'b0, 24'hFFFFFF},
		'{ROW_REG,        10'(qips_pkg::REG_CODE_BITS), 24'd2, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h01, 1'b1, 24'h010000},
		'{ROW_REG,        10'(qips_pkg::REG_CODE_BITS), 24'd8, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h40, 1'b1, 24'h010000},
		// writes to unused register slots do nothing
		'{ROW_REG,        10'(REG_SPARE_A), 24'h7FF, 7'h00, 1'b0, 24'h000000},
		'{ROW_REG,        10'(REG_SPARE_B), 24'h7FF, 7'h00, 1'b0, 24'h000000},
		// zero length acts as one
		'{ROW_REG,        10'(qips_pkg::REG_VECTOR_LENGTH), 24'd0, 7'h00, 1'b0, 24'h000000},
		'{ROW_LOAD,       10'd0,    24'h000001, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h55, 1'b1, 24'hFFFFFF},
		// three element vector with a load mid-scan, then the length cut short
		'{ROW_REG,        10'(qips_pkg::REG_VECTOR_LENGTH), 24'd3, 7'h00, 1'b0, 24'h000000},
		'{ROW_LOAD,       10'd1,    24'hFFFFFF, 7'h00, 1'b0, 24'h000000},
		'{ROW_LOAD,       10'd2,    24'h400000, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h03, 1'b1, 24'h000000},
		'{ROW_LOAD,       10'd1023, 24'h123456, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h02, 1'b0, 24'h000000},
		'{ROW_REG,        10'(qips_pkg::REG_VECTOR_LENGTH), 24'd1, 7'h00, 1'b0, 24'h000000},
		'{ROW_SCORE,      10'd0,    24'h000000, 7'h06, 1'b0, 24'hFFFFFF}
	};

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic [1:0]         cfg_index    = '0;
	logic [10:0]        cfg_data     = '0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic               kind         = 1'b0;
	logic [9:0]         coord_index  = '0;
	logic signed [23:0] query_value  = '0;
	logic [6:0]         level_code   = '0;
	logic               elem_sign    = 1'b0;
	logic [23:0]        vector_scale = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic signed [41:0] mse_part;
	logic        [42:0] qjl_part;
	logic signed [43:0] combined;

	// predictor state
	longint unsigned level_q [7][128];
	logic [22:0]     query_mag [qips_pkg::MAX_DIMENSION];
	logic            query_nonneg [qips_pkg::MAX_DIMENSION];
	int unsigned     elem_pos   = 0;
	logic [33:0]     base_acc   = '0;
	logic [33:0]     agree_acc  = '0;
	logic [10:0]     model_vlen = qips_pkg::VLEN_RESET;
	logic [3:0]      model_cbits = qips_pkg::CBITS_RESET;

	score_t          pending_scores [$];
	int              mismatches  = 0;
	int              idle_cycles = 0;
	idle_mode_t      idle_mode   = MODE_STEADY;

	quantized_inner_product_scorer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.coord_index  (coord_index),
		.query_value  (query_value),
		.level_code   (level_code),
		.elem_sign    (elem_sign),
		.vector_scale (vector_scale),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mse_part     (mse_part),
		.qjl_part     (qjl_part),
		.combined     (combined)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// build the companded level table: exp series in Q30, scaled by 1/mu, rounded to Q.16
	function automatic void build_levels();
		longint unsigned x;
		longint unsigned term;
		longint unsigned total;
		longint unsigned lev;
		longint unsigned m;
		int unsigned k;
		for (int s = 0; s < 7; s++) begin
			m = (64'd1 << (s + 1)) - 1;
			for (int c = 0; c < 128; c++) begin
				level_q[s][c] = 0;
				if (c <= m) begin
					x = (64'(c) * LN1P_Q30[s] + m / 2) / m;
					term = x;
					total = 0;
					k = 1;
					while (term != 0 && k <= 40) begin
						total = total + term;
						k = k + 1;
						term = ((term * x) >> 30) / k;
					end
					lev = (total * 4) / MU_Q[s];
					lev = (lev + (64'd1 << (29 - qips_pkg::FRACTION_BITS)))
						>> (30 - qips_pkg::FRACTION_BITS);
					if (lev > (64'd1 << qips_pkg::FRACTION_BITS))
						lev = 64'd1 << qips_pkg::FRACTION_BITS;
					level_q[s][c] = lev;
				end
			end
		end
	endfunction

	// advance the predicted state by one item; return 1 when it closes a vector
	function automatic bit predict_score(input item_t it, output score_t res);
		logic [24:0]     mag;
		int unsigned     bits;
		int unsigned     code;
		int unsigned     len;
		int unsigned     pos;
		longint unsigned weight;
		longint unsigned scale64;
		longint unsigned mse_mag;
		longint unsigned qjl;
		logic [63:0]     t;
		longint unsigned half;
		res = '0;
		half = 64'd1 << (qips_pkg::FRACTION_BITS - 1);
		if (it.kind == KIND_LOAD) begin
			if (it.qval[23]) begin
				mag = 25'h1000000 - {1'b0, it.qval};
				query_nonneg[it.coord] = 1'b0;
			end else begin
				mag = {1'b0, it.qval};
				query_nonneg[it.coord] = 1'b1;
			end
			if (mag > qips_pkg::MAG_MAX)
				mag = qips_pkg::MAG_MAX;
			query_mag[it.coord] = mag[22:0];
			return 1'b0;
		end
		bits = model_cbits < 2 ? 2 : (model_cbits > 8 ? 8 : model_cbits);
		code = it.code & ((1 << (bits - 1)) - 1);
		len = model_vlen == 0 ? 1 : (model_vlen > qips_pkg::MAX_DIMENSION ?
			qips_pkg::MAX_DIMENSION : model_vlen);
		pos = elem_pos % qips_pkg::MAX_DIMENSION;
		weight = (64'(query_mag[pos]) * level_q[bits - 2][code] + half)
			>> qips_pkg::FRACTION_BITS;
		base_acc = base_acc + weight[33:0];
		if (it.sgn == query_nonneg[pos])
			agree_acc = agree_acc + 34'(2 * weight);
		if (pos + 1 < len) begin
			elem_pos = pos + 1;
			return 1'b0;
		end
		scale64 = it.scale;
		mse_mag = (scale64 * base_acc + half) >> qips_pkg::FRACTION_BITS;
		qjl = (scale64 * agree_acc + half) >> qips_pkg::FRACTION_BITS;
		t = 64'd0 - mse_mag;
		res.mse = t[41:0];
		t = qjl;
		res.qjl = t[42:0];
		t = qjl - mse_mag;
		res.cmb = t[43:0];
		elem_pos = 0;
		base_acc = '0;
		agree_acc = '0;
		return 1'b1;
	endfunction

	function automatic item_t random_item(input bit is_load);
		item_t it;
		it.kind = is_load ? KIND_LOAD : KIND_SCORE;
		it.coord = 10'($urandom);
		case ($urandom_range(7))
			0: it.qval = 24'h800000;
			1: it.qval = 24'h7FFFFF;
			2: it.qval = 24'h000000;
			default: it.qval = 24'($urandom);
		endcase
		it.code = 7'($urandom);
		it.sgn = 1'($urandom);
		it.scale = ($urandom_range(7) == 0) ? 24'hFFFFFF : 24'($urandom);
		return it;
	endfunction

	// present one item, hold it until taken, then record the score it closes
	task automatic send_item(input item_t it, input bit zero_expected);
		score_t      res;
		int unsigned pct;
		pct = (idle_mode == MODE_SENDER_IDLE) ? 86 : (idle_mode == MODE_BOTH) ? 20 : 0;
		if ($urandom_range(99) < pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
		in_valid     <= 1'b1;
		kind         <= it.kind;
		coord_index  <= it.coord;
		query_value  <= it.qval;
		level_code   <= it.code;
		elem_sign    <= it.sgn;
		vector_scale <= it.scale;
		do @(posedge clk); while (in_stall);
		if (predict_score(it, res)) begin
			if (zero_expected)
				res = '0;
			pending_scores.push_back(res);
		end
	endtask

	// drop valid, wait for every pending score and let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == qips_pkg::REG_VECTOR_LENGTH)
			model_vlen = data;
		else if (idx == qips_pkg::REG_CODE_BITS)
			model_cbits = data[3:0];
		@(posedge clk);
	endtask

	// stall the output channel according to the current idling phase
	always @(posedge clk) begin
		case (idle_mode)
			MODE_RECEIVER_STALL: out_stall <= ($urandom_range(99) < 86);
			MODE_BOTH:           out_stall <= ($urandom_range(99) < 20);
			default:             out_stall <= 1'b0;
		endcase
	end

	// compare each output item against the oldest predicted score
	always @(posedge clk) begin
		score_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_scores.size() == 0) begin
				$error("score item with no expectation waiting: mse_part %0d", mse_part);
				mismatches++;
			end else begin
				want = pending_scores.pop_front();
				if (mse_part !== want.mse) begin
					$error("mse_part: expected %0d, got %0d", want.mse, mse_part);
					mismatches++;
				end
				if (qjl_part !== want.qjl) begin
					$error("qjl_part: expected %0d, got %0d", want.qjl, qjl_part);
					mismatches++;
				end
				if (combined !== want.cmb) begin
					$error("combined: expected %0d, got %0d", want.cmb, combined);
					mismatches++;
				end
			end
		end
	end

	// end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		row_t  row;
		item_t it;
		int    n;
		bit    big;
		build_levels();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corner cases
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.op == ROW_REG) begin
				settle();
				write_reg(row.index[1:0], row.value[10:0]);
			end else begin
				it.kind  = (row.op == ROW_LOAD) ? KIND_LOAD : KIND_SCORE;
				it.coord = row.index;
				it.qval  = row.value;
				it.code  = row.code;
				it.sgn   = row.sgn;
				it.scale = row.scale;
				send_item(it, row.op == ROW_SCORE_NULL);
			end
		end

		// fill the low part of the query store that every later scan reaches
		idle_mode = MODE_BOTH;
		for (int i = 0; i < FILL_ENTRIES; i++) begin
			it = random_item(1'b1);
			it.coord = 10'(i);
			send_item(it, 1'b0);
		end

		// random phases: mostly element streams with a few loads mixed in
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			idle_mode = idle_mode_t'(ph % 4);
			big = (ph == 6);
			if (big)
				write_reg(qips_pkg::REG_VECTOR_LENGTH, 11'h7FF);
			else if (ph == 3)
				write_reg(qips_pkg::REG_VECTOR_LENGTH, 11'd1);
			else
				write_reg(qips_pkg::REG_VECTOR_LENGTH, 11'($urandom_range(12)));
			write_reg(qips_pkg::REG_CODE_BITS, 11'($urandom_range(15)));
			n = PHASE_ITEMS;
			for (int j = 0; j < n; j++)
				send_item(random_item($urandom_range(99) < (big ? 3 : 12)), 1'b0);
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/qips_pkg.sv
rtl/qips_finish.sv
rtl/quantized_inner_product_scorer.sv
tb/tb_quantized_inner_product_scorer.sv
